// ===== src/bdh_pkg.sv =====
// Shared types and constants of the button debouncer with long-hold events.
package bdh_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int BTN_IDX_W   = 3;
    localparam int MS_W        = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [MS_W-1:0]      DEBOUNCE_RST = 16'd30;
    localparam logic [MS_W-1:0]      HOLD_RST     = 16'd3000;
    localparam logic [BTN_IDX_W-1:0] HOLD_BTN_RST = 3'd0;
    localparam logic [MS_W:0]        HOLD_CEIL    = 17'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_LIMIT = 2'd0,
        CFG_HOLD_LIMIT     = 2'd1,
        CFG_HOLD_BUTTON    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pin_levels;
        logic [MS_W-1:0]        delta_ms;
        logic [NUM_BUTTONS-1:0] ack_press;
        logic [NUM_BUTTONS-1:0] ack_release;
        logic                   ack_hold;
        logic [BTN_IDX_W-1:0]   query_button;
    } t_in_item;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] stable_pressed;
        logic [NUM_BUTTONS-1:0] press_pending;
        logic [NUM_BUTTONS-1:0] release_pending;
        logic                   hold_pending;
        logic [MS_W-1:0]        queried_hold_ms;
        logic [MS_W-1:0]        hold_remaining_ms;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic pin_level;
        logic ack_press;
        logic ack_release;
    } t_lane_ctrl;

    typedef struct packed {
        logic            stable;
        logic            press;
        logic            release_evt;
        logic            changed;
        logic [MS_W-1:0] hold_ms;
    } t_lane_stat;

endpackage

// ===== src/bdh_lane.sv =====
// One button lane: debounce accumulator, stable level, event latches and hold time.
module bdh_lane
    import bdh_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_lane_ctrl      i_ctrl,
    input  logic [MS_W-1:0] i_delta_ms,
    input  logic [MS_W-1:0] i_debounce_limit,
    output t_lane_stat      o_stat
);

    logic            r_stable;
    logic            r_press;
    logic            r_release;
    logic            r_changed;
    logic [MS_W-1:0] r_deb_ms;
    logic [MS_W-1:0] r_hold_ms;

    logic            n_stable;
    logic            n_press;
    logic            n_release;
    logic            n_changed;
    logic [MS_W-1:0] n_deb_ms;
    logic [MS_W-1:0] n_hold_ms;

    logic            raw;
    logic [MS_W:0]   deb_sum;
    logic [MS_W-1:0] deb_acc;
    logic [MS_W-1:0] hold_base;
    logic [MS_W:0]   hold_sum;

    always_comb begin
        raw      = ~i_ctrl.pin_level;
        deb_sum  = {1'b0, r_deb_ms} + {1'b0, i_delta_ms};
        deb_acc  = r_deb_ms;
        n_stable = r_stable;
        n_deb_ms = '0;
        if (raw != r_stable) begin
            if (r_deb_ms < i_debounce_limit) begin
                deb_acc = (deb_sum > {1'b0, i_debounce_limit}) ? i_debounce_limit
                                                               : deb_sum[MS_W-1:0];
            end
            if (deb_acc >= i_debounce_limit) begin
                n_stable = raw;
                n_deb_ms = '0;
            end else begin
                n_deb_ms = deb_acc;
            end
        end
        n_changed = (n_stable != r_stable);
        n_press   = (r_press & ~i_ctrl.ack_press) | (n_changed & n_stable);
        n_release = (r_release & ~i_ctrl.ack_release) | (n_changed & ~n_stable);
        hold_base = n_changed ? '0 : r_hold_ms;
        hold_sum  = {1'b0, hold_base} + {1'b0, i_delta_ms};
        n_hold_ms = hold_base;
        if (n_stable && (hold_sum < HOLD_CEIL)) begin
            n_hold_ms = hold_sum[MS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= 1'b0;
            r_press   <= 1'b0;
            r_release <= 1'b0;
            r_changed <= 1'b0;
            r_deb_ms  <= '0;
            r_hold_ms <= '0;
        end else if (i_ctrl.step) begin
            r_stable  <= n_stable;
            r_press   <= n_press;
            r_release <= n_release;
            r_changed <= n_changed;
            r_deb_ms  <= n_deb_ms;
            r_hold_ms <= n_hold_ms;
        end
    end

    assign o_stat.stable      = r_stable;
    assign o_stat.press       = r_press;
    assign o_stat.release_evt = r_release;
    assign o_stat.changed     = r_changed;
    assign o_stat.hold_ms     = r_hold_ms;

    a_edge_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_changed |-> (r_stable ? r_press : r_release))
        else $error("stable edge without its event latched");

    a_edge_hold_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.step && n_changed) |=> (r_hold_ms <= $past(i_delta_ms)))
        else $error("hold time not restarted on stable edge");

endmodule

// ===== src/bdh_merge.sv =====
// Merge stage: combines lane status into the result, owns the hold latch and output register.
module bdh_merge
    import bdh_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  t_lane_stat [NUM_BUTTONS-1:0]    i_stat,
    input  logic                            i_ack_hold,
    input  logic [BTN_IDX_W-1:0]            i_query,
    input  logic [BTN_IDX_W-1:0]            i_hold_button,
    input  logic [MS_W-1:0]                 i_hold_limit,
    output t_out_item                       o_item
);

    logic      r_hold_latch;
    t_out_item r_item;

    logic      n_hold_latch;
    t_out_item n_item;

    logic            hb_valid;
    t_lane_stat      hb_stat;
    logic            hb_reached;

    always_comb begin
        hb_valid   = (i_hold_button < BTN_IDX_W'(NUM_BUTTONS));
        hb_stat    = hb_valid ? i_stat[i_hold_button] : '0;
        hb_reached = (hb_stat.hold_ms >= i_hold_limit);

        n_hold_latch = r_hold_latch & ~i_ack_hold;
        if (hb_valid && hb_stat.changed) begin
            n_hold_latch = 1'b0;
        end
        if (hb_valid && hb_stat.stable && hb_reached) begin
            n_hold_latch = 1'b1;
        end

        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_item.stable_pressed[i]  = i_stat[i].stable;
            n_item.press_pending[i]   = i_stat[i].press;
            n_item.release_pending[i] = i_stat[i].release_evt;
        end
        n_item.hold_pending    = n_hold_latch;
        n_item.queried_hold_ms = (i_query < BTN_IDX_W'(NUM_BUTTONS)) ?
                                 i_stat[i_query].hold_ms : '0;
        if (!hb_valid || !hb_stat.stable) begin
            n_item.hold_remaining_ms = i_hold_limit;
        end else if (hb_reached) begin
            n_item.hold_remaining_ms = '0;
        end else begin
            n_item.hold_remaining_ms = i_hold_limit - hb_stat.hold_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_latch <= 1'b0;
        end else if (i_load) begin
            r_hold_latch <= n_hold_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

    a_remaining_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (n_item.hold_remaining_ms <= i_hold_limit))
        else $error("remaining hold time exceeds hold limit");

endmodule

// ===== src/button_debouncer_with_hold.sv =====
// Top level of the six-button debouncer with press, release and long-hold events.
//
//  channel  | signals                                  | dir | transfer when
//  ---------+------------------------------------------+-----+----------------------------
//  in       | i_in_valid, o_in_stall, i_in_item        | in  | i_in_valid && !o_in_stall
//  out      | o_out_valid, i_out_stall, o_out_item     | out | o_out_valid && !i_out_stall
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in  | i_cfg_valid && o_cfg_ready
//           | i_cfg_data                               |     |
//
//  One item per cycle unless the output stalls; o_out_valid rises once the item
//  has passed the lane registers and the output register. Lanes update all button
//  state at input transfer; merge forms result and hold event in the output register.
//  o_in_stall rises only while the lane stage holds an item and the output register
//  is full and stalled. Reset clears all button state and loads the register defaults.
module button_debouncer_with_hold
    import bdh_pkg::*;
#(
    parameter logic [MS_W-1:0]      DEBOUNCE_INIT = DEBOUNCE_RST,
    parameter logic [MS_W-1:0]      HOLD_INIT     = HOLD_RST,
    parameter logic [BTN_IDX_W-1:0] HOLD_BTN_INIT = HOLD_BTN_RST
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MS_W-1:0]      i_cfg_data
);

    logic [MS_W-1:0]      r_debounce_limit;
    logic [MS_W-1:0]      r_hold_limit;
    logic [BTN_IDX_W-1:0] r_hold_button;

    logic                 r_s1_valid;
    logic                 r_s1_ack_hold;
    logic [BTN_IDX_W-1:0] r_s1_query;
    logic                 r_out_valid;

    logic                 n_s1_valid;
    logic                 n_out_valid;

    logic                 in_xfer;
    logic                 advance;
    logic                 load;

    t_lane_ctrl [NUM_BUTTONS-1:0] lane_ctrl;
    t_lane_stat [NUM_BUTTONS-1:0] lane_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= DEBOUNCE_INIT;
            r_hold_limit     <= HOLD_INIT;
            r_hold_button    <= HOLD_BTN_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_data;
                CFG_HOLD_LIMIT:     r_hold_limit     <= i_cfg_data;
                CFG_HOLD_BUTTON:    r_hold_button    <= i_cfg_data[BTN_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance    = !r_out_valid || !i_out_stall;
    assign load       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = advance ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_ack_hold <= i_in_item.ack_hold;
            r_s1_query    <= i_in_item.query_button;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        assign lane_ctrl[g].step        = in_xfer;
        assign lane_ctrl[g].pin_level   = i_in_item.pin_levels[g];
        assign lane_ctrl[g].ack_press   = i_in_item.ack_press[g];
        assign lane_ctrl[g].ack_release = i_in_item.ack_release[g];

        bdh_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (lane_ctrl[g]),
            .i_delta_ms       (i_in_item.delta_ms),
            .i_debounce_limit (r_debounce_limit),
            .o_stat           (lane_stat[g])
        );
    end

    bdh_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_stat        (lane_stat),
        .i_ack_hold    (r_s1_ack_hold),
        .i_query       (r_s1_query),
        .i_hold_button (r_hold_button),
        .i_hold_limit  (r_hold_limit),
        .o_item        (o_out_item)
    );

    assign o_out_valid = r_out_valid;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_s1_valid) |=> !r_out_valid)
        else $error("result repeated after its transfer");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_s1_valid && !r_out_valid) |=> (r_s1_valid && !r_out_valid))
        else $error("accepted item lost before the merge stage");

endmodule
